// File: design/dmssr_pkg.sv
// ----------------------------------------------------------------------------
// dmssr_pkg
// Shared types and constants for the dual motor soft stop ramp block.
// ----------------------------------------------------------------------------
package dmssr_pkg;

  // field widths
  localparam int FREQ_W  = 16;
  localparam int STEPS_W = 5;
  localparam int ITER_W  = 4;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // ramp length limit
  localparam logic [STEPS_W-1:0] MAX_ITERS = 5'd16;

  // register reset values
  localparam logic [FREQ_W-1:0]  MAX_FREQ_RST    = 16'd65535;
  localparam logic [FREQ_W-1:0]  MIN_FREQ_RST    = 16'd0;
  localparam logic [FREQ_W-1:0]  FLOOR_FREQ_RST  = 16'd250;
  localparam logic [FREQ_W-1:0]  CUTOFF_FREQ_RST = 16'd500;
  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST  = 5'd12;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_MAX_FREQ    = 3'd0,
    REG_MIN_FREQ    = 3'd1,
    REG_FLOOR_FREQ  = 3'd2,
    REG_CUTOFF_FREQ = 3'd3,
    REG_RAMP_STEPS  = 3'd4
  } reg_idx_t;

  // input beat
  typedef struct packed {
    logic [FREQ_W-1:0] left_freq_now;
    logic [FREQ_W-1:0] right_freq_now;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [FREQ_W-1:0] left_freq_cmd;
    logic [FREQ_W-1:0] right_freq_cmd;
    logic              left_apply;
    logic              right_apply;
    logic              left_pause;
    logic              right_pause;
    logic              last;
  } out_item_t;

  // configuration registers
  typedef struct packed {
    logic [FREQ_W-1:0]  max_freq;
    logic [FREQ_W-1:0]  min_freq;
    logic [FREQ_W-1:0]  floor_freq;
    logic [FREQ_W-1:0]  cutoff_freq;
    logic [STEPS_W-1:0] ramp_steps;
  } cfg_regs_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [FREQ_W-1:0]  dividend;
    logic [STEPS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/dual_motor_soft_stop_ramp.sv
// ----------------------------------------------------------------------------
// dual_motor_soft_stop_ramp
// Soft stop for two stepper motors: ramps both step frequencies down over a
// programmable number of iterations, one result beat per iteration.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// in_       input      in_valid / in_ready        in_item_t  (present freqs)
// out_      output     out_valid / out_ready      out_item_t (commands, flags)
// apb       config     psel penable pwrite pready paddr / pwdata / prdata
//
// stopped request (both freqs at or below floor_freq): the accept cycle, then
// ST_PUT loads the single final beat. a ramp takes the accept cycle, the left
// and right start decrements on the one shared bit-serial divider, then one
// ST_ITER pass per iteration and a divide for each iteration where a motor
// joins. in_ready is high only while idle; a held beat that waits on out_ready
// stalls the sequencer. reset is synchronous, no clearing pass.
//
module dual_motor_soft_stop_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dmssr_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dmssr_pkg::out_item_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmssr_pkg::ADDR_W-1:0]        paddr,
  input  logic [dmssr_pkg::DATA_W-1:0]        pwdata,
  output logic [dmssr_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  dmssr_pkg::cfg_regs_t cfg_r, cfg_nxt;
  dmssr_pkg::reg_idx_t  reg_idx;
  dmssr_pkg::div_req_t  div_req;
  dmssr_pkg::div_rsp_t  div_rsp;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = dmssr_pkg::reg_idx_t'(paddr[dmssr_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        dmssr_pkg::REG_MAX_FREQ:    cfg_nxt.max_freq    = pwdata[dmssr_pkg::FREQ_W-1:0];
        dmssr_pkg::REG_MIN_FREQ:    cfg_nxt.min_freq    = pwdata[dmssr_pkg::FREQ_W-1:0];
        dmssr_pkg::REG_FLOOR_FREQ:  cfg_nxt.floor_freq  = pwdata[dmssr_pkg::FREQ_W-1:0];
        dmssr_pkg::REG_CUTOFF_FREQ: cfg_nxt.cutoff_freq = pwdata[dmssr_pkg::FREQ_W-1:0];
        dmssr_pkg::REG_RAMP_STEPS:  cfg_nxt.ramp_steps  = pwdata[dmssr_pkg::STEPS_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_freq    <= dmssr_pkg::MAX_FREQ_RST;
      cfg_r.min_freq    <= dmssr_pkg::MIN_FREQ_RST;
      cfg_r.floor_freq  <= dmssr_pkg::FLOOR_FREQ_RST;
      cfg_r.cutoff_freq <= dmssr_pkg::CUTOFF_FREQ_RST;
      cfg_r.ramp_steps  <= dmssr_pkg::RAMP_STEPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      dmssr_pkg::REG_MAX_FREQ:    prdata = dmssr_pkg::DATA_W'(cfg_r.max_freq);
      dmssr_pkg::REG_MIN_FREQ:    prdata = dmssr_pkg::DATA_W'(cfg_r.min_freq);
      dmssr_pkg::REG_FLOOR_FREQ:  prdata = dmssr_pkg::DATA_W'(cfg_r.floor_freq);
      dmssr_pkg::REG_CUTOFF_FREQ: prdata = dmssr_pkg::DATA_W'(cfg_r.cutoff_freq);
      dmssr_pkg::REG_RAMP_STEPS:  prdata = dmssr_pkg::DATA_W'(cfg_r.ramp_steps);
      default:                    prdata = '0;
    endcase
  end

  // ramp sequencer
  dmssr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  // shared divider
  dmssr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef SYNTHESIS
  // a request makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after accepting a request");

  // the divider is never busy while the sequencer is idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // while idle, a held result beat can only be the final one
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last)
    else $error("non-final beat pending while idle");

  // a divider start never lands on a running division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");
`endif

endmodule

// File: design/dmssr_div.sv
// ----------------------------------------------------------------------------
// dmssr_div
// Restoring divider, one quotient bit per cycle: 16-bit dividend by a
// divisor of 1 to 16. done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module dmssr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dmssr_pkg::div_req_t req,
  output dmssr_pkg::div_rsp_t rsp
);

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [dmssr_pkg::ITER_W-1:0]          cnt_r, cnt_nxt;
  logic [dmssr_pkg::ITER_W-1:0]          rem_r, rem_nxt;
  logic [dmssr_pkg::FREQ_W-1:0]          quo_r, quo_nxt;
  logic [dmssr_pkg::STEPS_W-1:0]         dvs_r, dvs_nxt;
  logic [dmssr_pkg::STEPS_W-1:0]         trial;
  logic                                  fits;

  // one restoring step
  assign trial = {rem_r, quo_r[dmssr_pkg::FREQ_W-1]};
  assign fits  = (trial >= dvs_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? dmssr_pkg::ITER_W'(trial - dvs_r) : trial[dmssr_pkg::ITER_W-1:0];
      quo_nxt = {quo_r[dmssr_pkg::FREQ_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: design/dmssr_seq.sv
// ----------------------------------------------------------------------------
// dmssr_seq
// Ramp sequencer: runs the stop ramp one iteration at a time, hands all
// divisions to the shared divider and holds the result beat in a register.
// ----------------------------------------------------------------------------
module dmssr_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dmssr_pkg::cfg_regs_t cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmssr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmssr_pkg::out_item_t out_data,
  output dmssr_pkg::div_req_t  div_req,
  input  dmssr_pkg::div_rsp_t  div_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_DIVL,
    ST_DIVR,
    ST_ITER,
    ST_JDIV
  } state_t;

  typedef struct packed {
    logic [dmssr_pkg::FREQ_W-1:0] freq;
    logic [dmssr_pkg::FREQ_W-1:0] dec;
    logic                         slow;
    logic                         pause;
  } motor_t;

  state_t                          state_r, state_nxt;
  motor_t                          lm_r, lm_nxt, rm_r, rm_nxt;
  logic [dmssr_pkg::STEPS_W-1:0]   steps_r, steps_nxt;
  logic [dmssr_pkg::ITER_W-1:0]    t_r, t_nxt;
  logic                            join_left_r, join_left_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dmssr_pkg::out_item_t            out_data_r, out_data_nxt;

  logic [dmssr_pkg::STEPS_W-1:0]   steps_c;
  logic [dmssr_pkg::STEPS_W-1:0]   remain;
  logic                            slot_free;
  logic                            is_last;
  logic                            rjoin, ljoin;
  motor_t                          lm_s, rm_s;

  // one ramp iteration for one motor: slow, zero at floor, park below cutoff
  function automatic motor_t step_motor(motor_t m,
                                        logic [dmssr_pkg::FREQ_W-1:0] floor_f,
                                        logic [dmssr_pkg::FREQ_W-1:0] cutoff_f);
    motor_t r;
    r = m;
    if (r.slow) begin
      r.freq = r.freq - r.dec;
    end
    if (r.freq == floor_f) begin
      r.freq  = '0;
      r.slow  = 1'b0;
      r.dec   = '0;
      r.pause = 1'b1;
    end
    if (r.freq < cutoff_f) begin
      r.freq  = floor_f;
      r.slow  = 1'b0;
      r.dec   = '0;
      r.pause = 1'b1;
    end
    return r;
  endfunction

  // ramp length clamped to 1..16
  always_comb begin
    if (cfg.ramp_steps == '0) begin
      steps_c = dmssr_pkg::STEPS_W'(1);
    end else if (cfg.ramp_steps > dmssr_pkg::MAX_ITERS) begin
      steps_c = dmssr_pkg::MAX_ITERS;
    end else begin
      steps_c = cfg.ramp_steps;
    end
  end

  // iteration datapath
  assign lm_s      = step_motor(lm_r, cfg.floor_freq, cfg.cutoff_freq);
  assign rm_s      = step_motor(rm_r, cfg.floor_freq, cfg.cutoff_freq);
  assign remain    = steps_r - {1'b0, t_r};
  assign is_last   = ({1'b0, t_r} == dmssr_pkg::STEPS_W'(steps_r - 1'b1));
  assign rjoin     = lm_s.slow && (rm_s.freq > lm_s.freq);
  assign ljoin     = !rjoin && rm_s.slow && (lm_s.freq > rm_s.freq);
  assign slot_free = !out_valid_r || out_ready;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    lm_nxt        = lm_r;
    rm_nxt        = rm_r;
    steps_nxt     = steps_r;
    t_nxt         = t_r;
    join_left_nxt = join_left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lm_nxt    = '0;
          rm_nxt    = '0;
          lm_nxt.freq = in_data.left_freq_now;
          rm_nxt.freq = in_data.right_freq_now;
          steps_nxt = steps_c;
          t_nxt     = '0;
          if (in_data.left_freq_now <= cfg.floor_freq &&
              in_data.right_freq_now <= cfg.floor_freq) begin
            state_nxt = ST_PUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = in_data.left_freq_now;
            div_req.divisor  = steps_c;
            state_nxt        = ST_DIVL;
          end
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.left_freq_cmd  = lm_r.freq;
          out_data_nxt.right_freq_cmd = rm_r.freq;
          out_data_nxt.left_apply     = 1'b0;
          out_data_nxt.right_apply    = 1'b0;
          out_data_nxt.left_pause     = 1'b1;
          out_data_nxt.right_pause    = 1'b1;
          out_data_nxt.last           = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end
      ST_DIVL: begin
        if (div_rsp.done) begin
          lm_nxt.dec       = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = rm_r.freq;
          div_req.divisor  = steps_r;
          state_nxt        = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_rsp.done) begin
          rm_nxt.dec  = div_rsp.quotient;
          lm_nxt.slow = (lm_r.freq >= rm_r.freq);
          rm_nxt.slow = (rm_r.freq >= lm_r.freq);
          state_nxt   = ST_ITER;
        end
      end
      ST_ITER: begin
        if (slot_free) begin
          lm_nxt                      = lm_s;
          rm_nxt                      = rm_s;
          out_valid_nxt               = 1'b1;
          out_data_nxt.left_freq_cmd  = lm_s.freq;
          out_data_nxt.right_freq_cmd = rm_s.freq;
          out_data_nxt.left_apply     = (lm_s.freq < cfg.max_freq) &&
                                        (lm_s.freq > cfg.min_freq);
          out_data_nxt.right_apply    = (rm_s.freq < cfg.max_freq) &&
                                        (rm_s.freq > cfg.min_freq);
          out_data_nxt.left_pause     = lm_s.pause;
          out_data_nxt.right_pause    = rm_s.pause;
          out_data_nxt.last           = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else if (rjoin) begin
            rm_nxt.slow      = 1'b1;
            join_left_nxt    = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = rm_s.freq;
            div_req.divisor  = remain;
            state_nxt        = ST_JDIV;
          end else if (ljoin) begin
            lm_nxt.slow      = 1'b1;
            join_left_nxt    = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = lm_s.freq;
            div_req.divisor  = remain;
            state_nxt        = ST_JDIV;
          end else begin
            t_nxt = t_r + 1'b1;
          end
        end
      end
      ST_JDIV: begin
        if (div_rsp.done) begin
          if (join_left_r) begin
            lm_nxt.dec = div_rsp.quotient;
          end else begin
            rm_nxt.dec = div_rsp.quotient;
          end
          t_nxt     = t_r + 1'b1;
          state_nxt = ST_ITER;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lm_r        <= lm_nxt;
    rm_r        <= rm_nxt;
    steps_r     <= steps_nxt;
    t_r         <= t_nxt;
    join_left_r <= join_left_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
